### design/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg: shared types and constants for the EDF scheduler
// Task table entry layout, completion record formats and field widths.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = ($clog2(MAX_TASKS) > 0) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NAME_W    = 8;
    localparam int FLD_W     = 15;
    localparam int TIME_W    = 21;

    // one row of the task table
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [FLD_W-1:0]  arrival;
        logic [FLD_W-1:0]  burst;
        logic [FLD_W-1:0]  remaining;
        logic [FLD_W-1:0]  deadline;
        logic              started;
        logic [TIME_W-1:0] first_run;
    } t_entry;

    // raw completion, before the derived times are worked out
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [FLD_W-1:0]  arrival;
        logic [FLD_W-1:0]  burst;
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] fin_t;
        logic              dropped;
    } t_emit;

    // finished completion record
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] fin_t;
        logic [TIME_W-1:0] resp_t;
        logic [TIME_W-1:0] tat_t;
        logic [TIME_W-1:0] wait_t;
        logic              dropped;
    } t_result;

endpackage

### design/edf_metrics.sv
// ----------------------------------------------------------------------------
// edf_metrics: completion record formatter
// Derives response, turnaround and waiting time from start and finish.
// ----------------------------------------------------------------------------
module edf_metrics (
    input  edf_pkg::t_emit   i_emit,
    output edf_pkg::t_result o_result
);

    logic [edf_pkg::TIME_W-1:0] arr_ext;
    logic [edf_pkg::TIME_W-1:0] burst_ext;
    logic [edf_pkg::TIME_W-1:0] tat;

    assign arr_ext   = edf_pkg::TIME_W'(i_emit.arrival);
    assign burst_ext = edf_pkg::TIME_W'(i_emit.burst);
    assign tat       = i_emit.fin_t - arr_ext;

    always_comb begin
        o_result.name    = i_emit.name;
        o_result.start_t = i_emit.start_t;
        o_result.fin_t   = i_emit.fin_t;
        o_result.resp_t  = i_emit.start_t - arr_ext;
        o_result.tat_t   = tat;
        o_result.wait_t  = tat - burst_ext;
        o_result.dropped = i_emit.dropped;
    end

endmodule

### design/edf_preemptive_scheduler.sv
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler: preemptive earliest-deadline-first scheduler
// Loads a task set, then simulates it in whole time units and reports each
// task as it completes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item (task) is accepted on a rising edge with start high
//   and busy low, so tasks can be loaded back to back. Up to MAX_TASKS tasks
//   are stored; later ones are dropped and flagged on every result of the set.
//   An item with i_last_task set starts the simulation; busy stays high until
//   the whole set is reported.
//   Output channel: each completion is on the o_ result ports for one cycle,
//   marked by o_result_valid. The receiver cannot stall; results just go.
//   Sequence: a sweep of the task table for zero-burst tasks, then per
//   schedule decision one sweep of the task table, then a step to pick the
//   run length and a step to write back; an idle gap costs one sweep plus
//   a jump of time. The single task table read port reads one entry a cycle.
//   The last result is on the ports after the final write-back and the flush
//   state, in the same cycle busy falls; the set is cleared by then.
//   Reset: synchronous, active low; empties the set and stops any simulation.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [edf_pkg::NAME_W-1:0]    i_task_name,
    input  logic [edf_pkg::FLD_W-1:0]     i_arrival_time,
    input  logic [edf_pkg::FLD_W-1:0]     i_burst_time,
    input  logic [edf_pkg::FLD_W-1:0]     i_deadline,
    input  logic                          i_last_task,
    output logic                          o_result_valid,
    output logic [edf_pkg::NAME_W-1:0]    o_done_name,
    output logic [edf_pkg::TIME_W-1:0]    o_start_time,
    output logic [edf_pkg::TIME_W-1:0]    o_end_time,
    output logic [edf_pkg::TIME_W-1:0]    o_response_time,
    output logic [edf_pkg::TIME_W-1:0]    o_turnaround_time,
    output logic [edf_pkg::TIME_W-1:0]    o_waiting_time,
    output logic                          o_last_result,
    output logic                          o_tasks_dropped
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ZERO   = 3'd1;  // report zero-burst tasks, count the rest
    localparam logic [2:0] S_SCAN   = 3'd2;  // sweep table: best ready task, next arrival
    localparam logic [2:0] S_DECIDE = 3'd3;  // pick run length or jump time
    localparam logic [2:0] S_UPDATE = 3'd4;  // advance time, write back, maybe complete
    localparam logic [2:0] S_FLUSH  = 3'd5;  // send held result as last, clear set

    localparam int CNT_W  = edf_pkg::CNT_W;
    localparam int IDX_W  = edf_pkg::IDX_W;
    localparam int FLD_W  = edf_pkg::FLD_W;
    localparam int TIME_W = edf_pkg::TIME_W;

    // task table
    edf_pkg::t_entry mem [edf_pkg::MAX_TASKS];
    edf_pkg::t_entry r_rd_data;
    edf_pkg::t_entry wr_data;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_overflow;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rv;
    logic [IDX_W-1:0]  r_rv_idx;
    logic [CNT_W-1:0]  r_left;

    logic              r_have_best;
    edf_pkg::t_entry   r_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_have_next;
    logic [FLD_W-1:0]  r_next;
    logic [FLD_W-1:0]  r_run;

    // one result is held back so the final one can be flagged
    logic              r_pend_v;
    edf_pkg::t_result  r_pend;

    logic              accept;
    logic              sweep_done;
    logic              emit_v;
    edf_pkg::t_emit    emit;
    edf_pkg::t_result  emit_res;

    logic [TIME_W-1:0] gap;
    logic [FLD_W-1:0]  n_run;
    logic [TIME_W-1:0] n_time;
    logic [FLD_W-1:0]  n_rem;
    logic [TIME_W-1:0] start_sel;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign sweep_done = (r_idx >= r_count) && !r_rv;
    assign rd_addr    = r_idx[IDX_W-1:0];

    // run length: up to the next arrival, which may preempt
    assign gap   = TIME_W'(r_next) - r_time;
    assign n_run = (r_have_next && (gap < TIME_W'(r_best.remaining)))
                   ? gap[FLD_W-1:0] : r_best.remaining;

    assign n_time    = r_time + TIME_W'(r_run);
    assign n_rem     = r_best.remaining - r_run;
    assign start_sel = r_best.started ? r_best.first_run : r_time;

    // table write port: loads in idle, write-back after a run
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = r_best;
        if (r_state == S_IDLE) begin
            wr_en             = accept && (r_count < CNT_W'(edf_pkg::MAX_TASKS));
            wr_data.name      = i_task_name;
            wr_data.arrival   = i_arrival_time;
            wr_data.burst     = i_burst_time;
            wr_data.remaining = i_burst_time;
            wr_data.deadline  = i_deadline;
            wr_data.started   = 1'b0;
            wr_data.first_run = '0;
        end else if (r_state == S_UPDATE) begin
            wr_en             = 1'b1;
            wr_addr           = r_best_idx;
            wr_data.remaining = n_rem;
            wr_data.started   = 1'b1;
            wr_data.first_run = start_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // completion source: zero-burst sweep or a finished run
    always_comb begin
        emit_v        = 1'b0;
        emit.name     = r_rd_data.name;
        emit.arrival  = r_rd_data.arrival;
        emit.burst    = r_rd_data.burst;
        emit.start_t  = TIME_W'(r_rd_data.arrival);
        emit.fin_t    = TIME_W'(r_rd_data.arrival);
        emit.dropped  = r_overflow;
        case (r_state)
            S_ZERO: begin
                emit_v = r_rv && (r_rd_data.remaining == '0);
            end
            S_UPDATE: begin
                emit_v       = (n_rem == '0);
                emit.name    = r_best.name;
                emit.arrival = r_best.arrival;
                emit.burst   = r_best.burst;
                emit.start_t = start_sel;
                emit.fin_t   = n_time;
            end
            default: begin
                emit_v = 1'b0;
            end
        endcase
    end

    edf_metrics u_metrics (
        .i_emit   (emit),
        .o_result (emit_res)
    );

    // result holding register and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            if (r_state == S_FLUSH) begin
                o_result_valid    <= r_pend_v;
                o_done_name       <= r_pend.name;
                o_start_time      <= r_pend.start_t;
                o_end_time        <= r_pend.fin_t;
                o_response_time   <= r_pend.resp_t;
                o_turnaround_time <= r_pend.tat_t;
                o_waiting_time    <= r_pend.wait_t;
                o_tasks_dropped   <= r_pend.dropped;
                o_last_result     <= 1'b1;
                r_pend_v          <= 1'b0;
            end else if (emit_v) begin
                o_result_valid    <= r_pend_v;
                o_done_name       <= r_pend.name;
                o_start_time      <= r_pend.start_t;
                o_end_time        <= r_pend.fin_t;
                o_response_time   <= r_pend.resp_t;
                o_turnaround_time <= r_pend.tat_t;
                o_waiting_time    <= r_pend.wait_t;
                o_tasks_dropped   <= r_pend.dropped;
                o_last_result     <= 1'b0;
                r_pend            <= emit_res;
                r_pend_v          <= 1'b1;
            end else begin
                o_result_valid    <= 1'b0;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_time     <= '0;
            r_idx      <= '0;
            r_rv       <= 1'b0;
            r_left     <= '0;
        end else begin
            // table sweep: issue one read a cycle, data registered and ready in the next cycle
            if (r_state == S_ZERO || r_state == S_SCAN) begin
                r_rv     <= (r_idx < r_count);
                r_rv_idx <= r_idx[IDX_W-1:0];
                if (r_idx < r_count) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_count < CNT_W'(edf_pkg::MAX_TASKS)) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_last_task) begin
                            r_state <= S_ZERO;
                            r_idx   <= '0;
                            r_rv    <= 1'b0;
                            r_left  <= '0;
                            r_time  <= '0;
                        end
                    end
                end
                S_ZERO: begin
                    if (r_rv && (r_rd_data.remaining != '0)) begin
                        r_left <= r_left + CNT_W'(1);
                    end
                    // read-valid already drops to zero at the end of a sweep
                    if (sweep_done) begin
                        r_idx       <= '0;
                        r_have_best <= 1'b0;
                        r_have_next <= 1'b0;
                        r_state     <= (r_left == '0) ? S_FLUSH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rv && (r_rd_data.remaining != '0)) begin
                        if (TIME_W'(r_rd_data.arrival) <= r_time) begin
                            // strict compare keeps the earlier-loaded task on ties
                            if (!r_have_best || (r_rd_data.deadline < r_best.deadline)) begin
                                r_have_best <= 1'b1;
                                r_best      <= r_rd_data;
                                r_best_idx  <= r_rv_idx;
                            end
                        end else if (!r_have_next || (r_rd_data.arrival < r_next)) begin
                            r_have_next <= 1'b1;
                            r_next      <= r_rd_data.arrival;
                        end
                    end
                    if (sweep_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_have_best) begin
                        r_run   <= n_run;
                        r_state <= S_UPDATE;
                    end else begin
                        // nothing ready: jump to the next arrival and rescan
                        r_time      <= TIME_W'(r_next);
                        r_idx       <= '0;
                        r_rv        <= 1'b0;
                        r_have_best <= 1'b0;
                        r_have_next <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_UPDATE: begin
                    r_time      <= n_time;
                    r_idx       <= '0;
                    r_rv        <= 1'b0;
                    r_have_best <= 1'b0;
                    r_have_next <= 1'b0;
                    if (n_rem == '0) begin
                        r_left  <= r_left - CNT_W'(1);
                        r_state <= (r_left == CNT_W'(1)) ? S_FLUSH : S_SCAN;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_FLUSH: begin
                    r_count    <= '0;
                    r_overflow <= 1'b0;
                    r_time     <= '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
